// ===== hdl/chm_pkg.sv =====
// Shared types and constants of the monotone-chain convex hull block.
// Used by the controller, the datapath and the top level; depends on nothing.
package chm_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_COORD_BITS = 16;
	localparam int SIZE_BITS      = 7;

	// Command address fields are sized for the largest capacity (64 points, 128 stack slots).
	localparam int ST_AW = 6;
	localparam int SK_AW = 7;

	typedef enum logic [1:0] {
		WSEL_IN,
		WSEL_V,
		WSEL_RD
	} st_wsel_t;

	typedef struct packed {
		logic               st_we;
		st_wsel_t           st_wsel;
		logic [ST_AW-1:0]   st_waddr;
		logic [ST_AW-1:0]   st_raddr;
		logic               v_ld;
		logic               pt_ld;
		logic               sk_we;
		logic [SK_AW-1:0]   sk_waddr;
		logic [SK_AW-1:0]   sk_raddr;
		logic               a_ld;
		logic               mul_ld;
		logic               out_ld;
		logic               out_last;
		logic [SIZE_BITS-1:0] out_size;
		logic               out_drop;
	} cmd_t;

	typedef struct packed {
		logic less;
		logic not_left;
		logic out_busy;
	} sts_t;

endpackage

// ===== hdl/chm_dp.sv =====
// Datapath of the convex hull block: point store, hull stack, cross product and output register.
// Depends on chm_pkg; driven by chm_ctrl through cmd_t and answers through sts_t.
module chm_dp #(
	parameter int POINT_CAPACITY = chm_pkg::DEF_CAPACITY,
	parameter int COORD_BITS     = chm_pkg::DEF_COORD_BITS,
	parameter int OUT_W          = ((2 * COORD_BITS + chm_pkg::SIZE_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  chm_pkg::cmd_t         cmd,
	output chm_pkg::sts_t         sts,
	input  logic [COORD_BITS-1:0] in_x,
	input  logic [COORD_BITS-1:0] in_y,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,
	output logic                  m_axis_tlast,
	output logic                  m_axis_tuser
);
	localparam int CB    = COORD_BITS;
	localparam int IDX_W = $clog2(POINT_CAPACITY);
	localparam int SKI_W = $clog2(2 * POINT_CAPACITY);
	localparam int PAD_W = OUT_W - 2 * CB - chm_pkg::SIZE_BITS;

	logic [2*CB-1:0] store_mem [POINT_CAPACITY];
	logic [2*CB-1:0] sk_mem [2*POINT_CAPACITY];
	logic [2*CB-1:0] st_rd_q, sk_rd_q, st_wdata;
	logic [2*CB-1:0] v_q, pt_q, a_q;
	logic signed [2*CB+1:0] prod1_q, prod2_q;
	logic signed [CB:0] dbx, dby, dpx, dpy;
	logic out_valid_q, out_last_q, out_drop_q;
	logic [chm_pkg::SIZE_BITS-1:0] out_size_q;
	logic [2*CB-1:0] out_pt_q;

	always_comb begin
		case (cmd.st_wsel)
			chm_pkg::WSEL_V:  st_wdata = v_q;
			chm_pkg::WSEL_RD: st_wdata = st_rd_q;
			default:          st_wdata = {in_y, in_x};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.st_we) begin
			store_mem[cmd.st_waddr[IDX_W-1:0]] <= st_wdata;
		end
		st_rd_q <= store_mem[cmd.st_raddr[IDX_W-1:0]];
		if (cmd.sk_we) begin
			sk_mem[cmd.sk_waddr[SKI_W-1:0]] <= pt_q;
		end
		sk_rd_q <= sk_mem[cmd.sk_raddr[SKI_W-1:0]];
	end

	// Turn test: b is the stack top just read, a the entry below it, p the candidate point.
	assign dbx = $signed({sk_rd_q[CB-1], sk_rd_q[CB-1:0]}) - $signed({a_q[CB-1], a_q[CB-1:0]});
	assign dby = $signed({sk_rd_q[2*CB-1], sk_rd_q[2*CB-1:CB]})
		- $signed({a_q[2*CB-1], a_q[2*CB-1:CB]});
	assign dpx = $signed({pt_q[CB-1], pt_q[CB-1:0]}) - $signed({a_q[CB-1], a_q[CB-1:0]});
	assign dpy = $signed({pt_q[2*CB-1], pt_q[2*CB-1:CB]})
		- $signed({a_q[2*CB-1], a_q[2*CB-1:CB]});

	always_ff @(posedge clk) begin
		if (cmd.v_ld) begin
			v_q <= st_rd_q;
		end
		if (cmd.pt_ld) begin
			pt_q <= st_rd_q;
		end
		if (cmd.a_ld) begin
			a_q <= sk_rd_q;
		end
		if (cmd.mul_ld) begin
			prod1_q <= dbx * dpy;
			prod2_q <= dby * dpx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_pt_q   <= sk_rd_q;
			out_size_q <= cmd.out_size;
			out_last_q <= cmd.out_last;
			out_drop_q <= cmd.out_drop;
		end
	end

	assign sts.less = ($signed(v_q[CB-1:0]) < $signed(st_rd_q[CB-1:0]))
		|| (v_q[CB-1:0] == st_rd_q[CB-1:0]
		&& $signed(v_q[2*CB-1:CB]) < $signed(st_rd_q[2*CB-1:CB]));
	assign sts.not_left = (prod1_q <= prod2_q);
	assign sts.out_busy = out_valid_q && !m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_size_q, out_pt_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_drop_q;

endmodule

// ===== hdl/chm_ctrl.sv =====
// Controller of the convex hull block: load, insertion sort, chain walk and emit sequencing.
// Depends on chm_pkg; commands chm_dp through cmd_t and reads its sts_t.
module chm_ctrl #(
	parameter int POINT_CAPACITY = chm_pkg::DEF_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	output chm_pkg::cmd_t cmd,
	input  chm_pkg::sts_t sts
);
	localparam int CNT_W = $clog2(POINT_CAPACITY + 1);
	localparam int SK_W  = $clog2(2 * POINT_CAPACITY + 1);

	typedef enum logic [3:0] {
		S_LOAD, S_SRD_I, S_SWAIT_I, S_SCMP, S_SPUT,
		S_HRDP, S_HWP, S_HRDA, S_HRDB, S_HMUL, S_HCMP, S_HPUSH, S_HFIN,
		S_ERD, S_ELD
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q, n_q, i_q, j_q, p_q, e_q, emit;
	logic [SK_W-1:0] m_q, k_q, lim, m_push;
	logic upper_q, ovf_q, has_room, e_last;

	assign has_room = cnt_q < CNT_W'(POINT_CAPACITY);
	assign lim      = upper_q ? k_q : SK_W'(1);
	assign m_push   = (m_q < SK_W'(2 * POINT_CAPACITY)) ? m_q + SK_W'(1) : m_q;
	assign emit     = (m_q > SK_W'(POINT_CAPACITY)) ? CNT_W'(POINT_CAPACITY) : CNT_W'(m_q);
	assign e_last   = (e_q + CNT_W'(1)) == emit;
	assign in_ready = (state_q == S_LOAD);

	always_comb begin
		cmd = '0;
		cmd.st_wsel = chm_pkg::WSEL_IN;
		unique case (state_q)
			S_LOAD: begin
				cmd.st_we    = in_valid && has_room;
				cmd.st_waddr = chm_pkg::ST_AW'(cnt_q);
			end
			S_SRD_I: cmd.st_raddr = chm_pkg::ST_AW'(i_q);
			S_SWAIT_I: begin
				cmd.v_ld     = 1'b1;
				cmd.st_raddr = chm_pkg::ST_AW'(j_q - CNT_W'(1));
			end
			S_SCMP: begin
				cmd.st_we    = 1'b1;
				cmd.st_waddr = chm_pkg::ST_AW'(j_q);
				cmd.st_wsel  = sts.less ? chm_pkg::WSEL_RD : chm_pkg::WSEL_V;
				cmd.st_raddr = chm_pkg::ST_AW'(j_q - CNT_W'(2));
			end
			S_SPUT: begin
				cmd.st_we    = 1'b1;
				cmd.st_waddr = chm_pkg::ST_AW'(j_q);
				cmd.st_wsel  = chm_pkg::WSEL_V;
			end
			S_HRDP: cmd.st_raddr = chm_pkg::ST_AW'(p_q);
			S_HWP: cmd.pt_ld = 1'b1;
			S_HRDA: cmd.sk_raddr = chm_pkg::SK_AW'(m_q - SK_W'(2));
			S_HRDB: begin
				cmd.a_ld     = 1'b1;
				cmd.sk_raddr = chm_pkg::SK_AW'(m_q - SK_W'(1));
			end
			S_HMUL: cmd.mul_ld = 1'b1;
			S_HCMP, S_HFIN: begin
			end
			S_HPUSH: begin
				cmd.sk_we    = m_q < SK_W'(2 * POINT_CAPACITY);
				cmd.sk_waddr = chm_pkg::SK_AW'(m_q);
			end
			S_ERD: cmd.sk_raddr = chm_pkg::SK_AW'(e_q);
			S_ELD: begin
				cmd.sk_raddr = chm_pkg::SK_AW'(e_q);
				cmd.out_ld   = !sts.out_busy;
				cmd.out_last = e_last;
				cmd.out_size = chm_pkg::SIZE_BITS'(emit);
				cmd.out_drop = ovf_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			p_q     <= '0;
			e_q     <= '0;
			m_q     <= '0;
			k_q     <= '0;
			upper_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (has_room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							n_q     <= has_room ? cnt_q + CNT_W'(1) : cnt_q;
							i_q     <= CNT_W'(1);
							state_q <= S_SRD_I;
						end
					end
				end
				S_SRD_I: begin
					if (i_q >= n_q) begin
						p_q     <= '0;
						m_q     <= '0;
						upper_q <= 1'b0;
						state_q <= S_HRDP;
					end else begin
						j_q     <= i_q;
						state_q <= S_SWAIT_I;
					end
				end
				S_SWAIT_I: state_q <= S_SCMP;
				S_SCMP: begin
					if (sts.less) begin
						j_q <= j_q - CNT_W'(1);
						if (j_q == CNT_W'(1)) begin
							state_q <= S_SPUT;
						end
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_SRD_I;
					end
				end
				S_SPUT: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= S_SRD_I;
				end
				S_HRDP: state_q <= S_HWP;
				S_HWP: state_q <= (m_q > lim) ? S_HRDA : S_HPUSH;
				S_HRDA: state_q <= S_HRDB;
				S_HRDB: state_q <= S_HMUL;
				S_HMUL: state_q <= S_HCMP;
				S_HCMP: begin
					if (sts.not_left) begin
						m_q     <= m_q - SK_W'(1);
						state_q <= ((m_q - SK_W'(1)) > lim) ? S_HRDA : S_HPUSH;
					end else begin
						state_q <= S_HPUSH;
					end
				end
				S_HPUSH: begin
					m_q <= m_push;
					if (!upper_q) begin
						if (p_q == n_q - CNT_W'(1)) begin
							k_q     <= m_push;
							upper_q <= 1'b1;
							if (n_q > CNT_W'(1)) begin
								p_q     <= n_q - CNT_W'(2);
								state_q <= S_HRDP;
							end else begin
								state_q <= S_HFIN;
							end
						end else begin
							p_q     <= p_q + CNT_W'(1);
							state_q <= S_HRDP;
						end
					end else if (p_q == '0) begin
						state_q <= S_HFIN;
					end else begin
						p_q     <= p_q - CNT_W'(1);
						state_q <= S_HRDP;
					end
				end
				S_HFIN: begin
					// The upper chain ends on the first vertex again; drop that copy.
					if (n_q > CNT_W'(1)) begin
						m_q <= m_q - SK_W'(1);
					end
					e_q     <= '0;
					state_q <= S_ERD;
				end
				S_ERD: state_q <= S_ELD;
				S_ELD: begin
					if (!sts.out_busy) begin
						if (e_last) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							e_q     <= e_q + CNT_W'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// ===== hdl/convex_hull_monotone_chain.sv =====
// Top level of the convex hull block: stream ports, controller and datapath.
// Depends on chm_pkg, chm_ctrl and chm_dp.
//
// Points stream in on the slave side, one beat per cycle while the block is loading,
// and are kept in a point memory of POINT_CAPACITY entries; the beat with tlast closes
// the set. Points that arrive when the memory is full are discarded and reported through
// tuser on every vertex of that hull. The block then sorts the points by x and then y
// with an insertion sort over the point memory, which has one write and one read port,
// and walks Andrew's monotone chain, lower chain first, keeping the chain in a stack
// memory of 2*POINT_CAPACITY entries. Each point visit reads the point into a register
// and ends with a push, and each turn test takes two stack reads, a registered pair of
// products and a compare; collinear points are popped. Vertices then leave on the master
// side in chain order, each read from the stack and then loaded into the output register
// when the sink is not stalling it, each carrying the hull size, with tlast on the final
// vertex. Input is held off from the closing beat until the final vertex has been loaded
// into the output register; the next set may load while that vertex still waits to be
// taken. Memory contents need no clearing after reset.
module convex_hull_monotone_chain #(
	parameter int POINT_CAPACITY = chm_pkg::DEF_CAPACITY,
	parameter int COORD_BITS     = chm_pkg::DEF_COORD_BITS,
	parameter int IN_W           = ((2 * COORD_BITS + 7) / 8) * 8,
	parameter int OUT_W          = ((2 * COORD_BITS + chm_pkg::SIZE_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // point_x, point_y, zero fill
	input  logic             s_axis_tlast,  // last_point
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,  // vertex_x, vertex_y, hull_size, zero fill
	output logic             m_axis_tlast,  // last_vertex
	output logic             m_axis_tuser   // points_dropped
);
	chm_pkg::cmd_t cmd;
	chm_pkg::sts_t sts;

	chm_ctrl #(
		.POINT_CAPACITY(POINT_CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	chm_dp #(
		.POINT_CAPACITY(POINT_CAPACITY),
		.COORD_BITS    (COORD_BITS),
		.OUT_W         (OUT_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_x          (s_axis_tdata[COORD_BITS-1:0]),
		.in_y          (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== hdl/chm_checker.sv =====
// Port-level checks for the convex hull block, bound to the top level.
// Depends on convex_hull_monotone_chain and chm_pkg.
module chm_checker #(
	parameter int POINT_CAPACITY = chm_pkg::DEF_CAPACITY,
	parameter int COORD_BITS     = chm_pkg::DEF_COORD_BITS,
	parameter int OUT_W          = ((2 * COORD_BITS + chm_pkg::SIZE_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             s_axis_tlast,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic             m_axis_tlast,
	input logic             m_axis_tuser
);
	logic [chm_pkg::SIZE_BITS-1:0] size;
	assign size = m_axis_tdata[2*COORD_BITS+chm_pkg::SIZE_BITS-1:2*COORD_BITS];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output beat changed while stalled");

	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken right after the closing point");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> size != '0
		&& size <= chm_pkg::SIZE_BITS'(POINT_CAPACITY))
		else $error("hull size out of range");

	a_size_steady: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
		|-> size == $past(size))
		else $error("hull size changed within a run");

endmodule

bind convex_hull_monotone_chain chm_checker #(
	.POINT_CAPACITY(POINT_CAPACITY),
	.COORD_BITS    (COORD_BITS),
	.OUT_W         (OUT_W)
) u_chm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the monotone-chain convex hull block.
// Depends on chm_pkg and convex_hull_monotone_chain; checks every hull vertex.
`timescale 1ns / 1ps

module tb;

	localparam int CAP       = chm_pkg::DEF_CAPACITY;
	localparam int CB        = chm_pkg::DEF_COORD_BITS;
	localparam int SIZE_BITS = chm_pkg::SIZE_BITS;
	localparam int IN_W  = ((2 * CB + 7) / 8) * 8;
	localparam int OUT_W = ((2 * CB + SIZE_BITS + 7) / 8) * 8;
	// Beats of silence on both sides after which the run is declared hung.
	localparam int STALL_LIMIT = 40000;
	localparam int LONG_HOLD   = 3000;

	typedef struct {
		logic signed [CB-1:0]  x;
		logic signed [CB-1:0]  y;
		logic [SIZE_BITS-1:0] size;
		logic                 last;
		logic                 drop;
	} vertex_t;

	// Keeps its own copy of the point set and works out each hull when the set closes.
	class hull_scoreboard;
		longint  set_x[$];
		longint  set_y[$];
		bit      overflow;
		vertex_t hull_fifo[$];
		int      errors;

		function new();
			overflow = 0;
			errors   = 0;
		endfunction

		// True when the turn o -> a -> b is clockwise or straight.
		function bit turn_not_left(longint ox, longint oy, longint ax, longint ay,
		                           longint bx, longint by);
			return ((ax - ox) * (by - oy) - (ay - oy) * (bx - ox)) <= 0;
		endfunction

		function void note_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y, bit last);
			longint  sx[$];
			longint  sy[$];
			longint  kx[2*CAP];
			longint  ky[2*CAP];
			longint  tx, ty;
			int      n, m, k, j, emit;
			vertex_t v;
			if (set_x.size() < CAP) begin
				set_x.push_back(longint'(x));
				set_y.push_back(longint'(y));
			end else begin
				overflow = 1;
			end
			if (!last)
				return;
			sx = set_x;
			sy = set_y;
			n  = sx.size();
			// Insertion sort by x, then y.
			for (int i = 1; i < n; i++) begin
				tx = sx[i];
				ty = sy[i];
				j  = i;
				while (j > 0 && (tx < sx[j-1] || (tx == sx[j-1] && ty < sy[j-1]))) begin
					sx[j] = sx[j-1];
					sy[j] = sy[j-1];
					j--;
				end
				sx[j] = tx;
				sy[j] = ty;
			end
			// Lower chain, then upper chain on the same stack.
			m = 0;
			for (int i = 0; i < n; i++) begin
				while (m > 1 && turn_not_left(kx[m-2], ky[m-2], kx[m-1], ky[m-1], sx[i], sy[i]))
					m--;
				kx[m] = sx[i];
				ky[m] = sy[i];
				m++;
			end
			k = m;
			for (int i = n - 2; i >= 0; i--) begin
				while (m > k && turn_not_left(kx[m-2], ky[m-2], kx[m-1], ky[m-1], sx[i], sy[i]))
					m--;
				if (m < 2 * CAP) begin
					kx[m] = sx[i];
					ky[m] = sy[i];
					m++;
				end
			end
			// The closing vertex repeats the first one unless the set is a single point.
			if (n > 1)
				m--;
			emit = (m > CAP) ? CAP : m;
			for (int i = 0; i < emit; i++) begin
				v.x    = kx[i][CB-1:0];
				v.y    = ky[i][CB-1:0];
				v.size = emit[SIZE_BITS-1:0];
				v.last = (i + 1 == emit);
				v.drop = overflow;
				hull_fifo.push_back(v);
			end
			set_x.delete();
			set_y.delete();
			overflow = 0;
		endfunction

		function void check_vertex(vertex_t got);
			vertex_t exp_v;
			if (hull_fifo.size() == 0) begin
				$error("vertex beat with no vertex expected: x=%0d y=%0d", got.x, got.y);
				errors++;
				return;
			end
			exp_v = hull_fifo.pop_front();
			if (got.x !== exp_v.x) begin
				$error("vertex_x: expected %0d, got %0d", exp_v.x, got.x);
				errors++;
			end
			if (got.y !== exp_v.y) begin
				$error("vertex_y: expected %0d, got %0d", exp_v.y, got.y);
				errors++;
			end
			if (got.size !== exp_v.size) begin
				$error("hull_size: expected %0d, got %0d", exp_v.size, got.size);
				errors++;
			end
			if (got.last !== exp_v.last) begin
				$error("last_vertex: expected %0d, got %0d", exp_v.last, got.last);
				errors++;
			end
			if (got.drop !== exp_v.drop) begin
				$error("points_dropped: expected %0d, got %0d", exp_v.drop, got.drop);
				errors++;
			end
		endfunction

		function int pending();
			return hull_fifo.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;   // point_x, point_y, zero fill
	logic             s_axis_tlast;   // last_point
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;   // vertex_x, vertex_y, hull_size, zero fill
	logic             m_axis_tlast;   // last_vertex
	logic             m_axis_tuser;   // points_dropped

	convex_hull_monotone_chain dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	hull_scoreboard hull_sb = new();

	// Idle and stall rates in percent, changed by the stimulus from phase to phase.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// The stimulus bumps hold_requests; the sink process serves each with one long hold-off.
	int hold_requests  = 0;
	int holds_served   = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	int points_sent    = 0;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Sink side: random stalls plus the long hold-off that lets the block back up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (holds_served < hold_requests) begin
			holds_served  <= holds_served + 1;
			hold_left     <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Every vertex beat is checked against the oldest expected vertex.
	always @(posedge clk) begin
		vertex_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.x    = m_axis_tdata[CB-1:0];
			got.y    = m_axis_tdata[2*CB-1:CB];
			got.size = m_axis_tdata[2*CB+SIZE_BITS-1:2*CB];
			got.last = m_axis_tlast;
			got.drop = m_axis_tuser;
			hull_sb.check_vertex(got);
		end
	end

	// Watchdog: the sort and the chain walk keep both sides quiet for a while, but never
	// for this long, even with the long hold-off on top.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Offers one point and returns after the beat is taken. Valid stays high afterwards,
	// so back-to-back beats never see valid dropped and raised in the same step.
	// Coordinates are given as integers and keep their low CB bits.
	task automatic send_point(input int x, input int y, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_W'({CB'(y), CB'(x)});
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		hull_sb.note_point(CB'(x), CB'(y), last);
		points_sent++;
	endtask

	// A set of n random points; narrow sets favor repeats and collinear runs.
	task automatic send_random_set(input int n, input bit narrow);
		int x, y;
		for (int i = 0; i < n; i++) begin
			if (narrow) begin
				x = int'($urandom_range(8)) - 4;
				y = int'($urandom_range(8)) - 4;
			end else begin
				x = int'($urandom_range(65535)) - 32768;
				y = int'($urandom_range(65535)) - 32768;
			end
			send_point(x, y, i == n - 1);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (hull_sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int n;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets: a lone point at the corner, another at the opposite corner,
		// three identical points, a straight line, a square at the coordinate extremes with
		// its center and an edge midpoint that must both fall away, and a pair of points.
		send_point(-32768, -32768, 1);
		send_point(32767, 32767, 1);
		send_point(5, -7, 0);
		send_point(5, -7, 0);
		send_point(5, -7, 1);
		send_point(0, 0, 0);
		send_point(3, 3, 0);
		send_point(1, 1, 0);
		send_point(2, 2, 1);
		send_point(32767, -32768, 0);
		send_point(-32768, -32768, 0);
		send_point(0, 0, 0);
		send_point(-32768, 32767, 0);
		send_point(32767, 32767, 0);
		send_point(0, -32768, 1);
		send_point(-1, 0, 0);
		send_point(1, 0, 1);
		wait_drained();

		// Random sets over four idling phases. Most sets are small; a few fill the memory,
		// and one overruns it so the closing beat itself is discarded.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 84;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 84;
				end
				default: begin
					send_idle_pct  = 7;
					recv_stall_pct = 7;
				end
			endcase
			if (phase == 0) begin
				send_random_set(CAP + 6, 0);
				hold_requests++;
				send_random_set(40, 0);
				send_random_set(5, 1);
				send_random_set(4, 0);
				wait_drained();
			end
			if (phase == 3)
				send_random_set(CAP, 0);
			while (points_sent < 10 + 85 * (phase + 1)) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(CAP, 20) : $urandom_range(12, 1);
				send_random_set(n, $urandom_range(2) == 0);
			end
			// Burst of stretches with no idling inside each phase.
			send_idle_pct  = 0;
			recv_stall_pct = 0;
			send_random_set(6, 0);
		end

		wait_drained();
		if (hull_sb.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/chm_pkg.sv
hdl/chm_dp.sv
hdl/chm_ctrl.sv
hdl/convex_hull_monotone_chain.sv
hdl/chm_checker.sv
verif/tb.sv
